// ===== hw/rtl/stochastic_kronecker_edge_sampler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Kronecker edge sampler assertion macros
// Concurrent check helpers, removed when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef STOCHASTIC_KRONECKER_EDGE_SAMPLER_TOP_DEFINES_SVH
`define STOCHASTIC_KRONECKER_EDGE_SAMPLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SKE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ske assertion failed");
// next-cycle implication
`define SKE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ske assertion failed");
`else
`define SKE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ske_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kronecker edge sampler package
// Sizes, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ske_pkg;

  // geometry
  localparam int MAX_SIDE   = 4;
  localparam int COORD_BITS = 8;
  localparam int PROB_BITS  = 16;

  localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int SIDE_W    = $clog2(MAX_SIDE);
  localparam int ROWS      = 1 << COORD_BITS;
  localparam int SLOT_W    = 16;
  localparam int SLOTS     = 4;

  // register field widths
  localparam int SIDE_CFG_W = 3;
  localparam int LEVEL_W    = 4;
  localparam int NODE_W     = 9;
  localparam int COUNT_W    = 17;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DRAW_W     = 16;
  localparam int OUT_COORD_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIDE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TGT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_A      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_B      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THR_C      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THR_D      = 3'd7;

  // input command codes
  localparam logic CMD_DRAW    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic restart;  // clear counters and rewind the clear pointer
    logic step;     // take one digit from the draw
    logic ignore;   // draw dropped after finishing
    logic clr_row;  // zero one bitmap row
    logic check;    // bitmap read-modify-write and result
  } ske_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;        // target reached, draws are dropped
    logic last_level;  // this draw completes an edge
    logic clr_last;    // clear pointer on last row
  } ske_stat_t;

endpackage

// ===== hw/rtl/ske_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kronecker edge sampler controller
// Sequences bitmap clearing, digit steps and the bitmap update
// ----------------------------------------------------------------------------
module ske_ctrl
  import ske_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_cmd,
  input  ske_stat_t stat,
  output ske_cmd_t  cmd,
  output logic      busy
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;
  logic       draw_acc;

  // request handshake
  assign accept   = start && (state_r == ST_IDLE);
  assign draw_acc = accept && (in_cmd == CMD_DRAW);
  assign busy     = (state_r != ST_IDLE);

  // command decode
  always_comb begin
    cmd.restart = accept && (in_cmd == CMD_RESTART);
    cmd.step    = draw_acc && !stat.skip;
    cmd.ignore  = draw_acc && stat.skip;
    cmd.clr_row = (state_r == ST_CLEAR);
    cmd.check   = (state_r == ST_CHECK);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.restart) state_nxt = ST_CLEAR;
        else if (cmd.step && stat.last_level) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/ske_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kronecker edge sampler datapath
// Registers, threshold compare, coordinate accumulators and edge bitmap
// ----------------------------------------------------------------------------
module ske_datapath
  import ske_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [DRAW_W-1:0]      in_draw,
  input  ske_cmd_t               cmd,
  output ske_stat_t              stat,
  output logic                   out_valid,
  output logic [OUT_COORD_W-1:0] out_edge_row,
  output logic [OUT_COORD_W-1:0] out_edge_col,
  output logic                   out_new_edge,
  output logic                   out_inside_res,
  output logic                   out_finished
);

  // configuration registers
  logic [SIDE_CFG_W-1:0] side_r;
  logic [LEVEL_W-1:0]    levels_r;
  logic [NODE_W-1:0]     node_count_r;
  logic [COUNT_W-1:0]    edge_target_r;
  logic [CFG_DATA_W-1:0] thr_r [SLOTS];

  // run state
  logic [LEVEL_W-1:0]    level_r;
  logic [COORD_BITS-1:0] row_r, col_r;
  logic [COUNT_W-1:0]    placed_r;
  logic                  done_r;
  logic [COORD_BITS-1:0] clr_addr_r;
  logic [COORD_BITS-1:0] edge_row_r, edge_col_r;

  // bitmap, one row of edges per word
  logic [ROWS-1:0] bitmap_mem [ROWS];
  logic [ROWS-1:0] rd_q;

  // output registers
  logic                   out_valid_r;
  logic [OUT_COORD_W-1:0] out_row_r, out_col_r;
  logic                   out_new_r, out_inside_r, out_fin_r;

  // digit logic
  logic [SIDE_CFG_W-1:0]  s;
  logic [CELL_W:0]        cells;
  logic [PROB_BITS-1:0]   draw_v;
  logic [MAX_CELLS-2:0]   match;
  logic [CELL_W-1:0]      hit;
  logic [SIDE_W-1:0]      q_dig, r_dig;
  logic [CELL_W-1:0]      r_full;
  logic [COORD_BITS+SIDE_CFG_W-1:0] row_ext, col_ext;
  logic [COORD_BITS-1:0]  row_new, col_new;
  logic [LEVEL_W-1:0]     level_new, lv;

  // check logic
  logic                   is_new;
  logic [COUNT_W-1:0]     placed_nxt;
  logic                   done_nxt;
  logic [ROWS-1:0]        wr_row;

  // clamp side, compare draw against each cumulative threshold
  always_comb begin
    if (side_r < SIDE_CFG_W'(2))             s = SIDE_CFG_W'(2);
    else if (side_r > SIDE_CFG_W'(MAX_SIDE)) s = SIDE_CFG_W'(MAX_SIDE);
    else                                     s = side_r;
    cells  = (CELL_W+1)'(s) * (CELL_W+1)'(s);
    draw_v = in_draw[PROB_BITS-1:0];
    for (int k = 0; k < MAX_CELLS - 1; k++) begin
      match[k] = ((CELL_W+1)'(k + 1) < cells) &&
                 (draw_v <= thr_r[k / SLOTS][SLOT_W * (k % SLOTS) +: PROB_BITS]);
    end
  end

  // first matching cell, last cell when nothing matches
  always_comb begin
    hit = CELL_W'(cells - (CELL_W+1)'(1));
    for (int k = MAX_CELLS - 2; k >= 0; k--) begin
      if (match[k]) hit = CELL_W'(k);
    end
  end

  // split cell into row digit and column digit
  always_comb begin
    q_dig = '0;
    for (int d = 1; d < MAX_SIDE; d++) begin
      if ((CELL_W+1)'(hit) >= (CELL_W+1)'(d) * (CELL_W+1)'(s)) q_dig = SIDE_W'(d);
    end
    r_full = hit - CELL_W'(q_dig) * CELL_W'(s);
    r_dig  = r_full[SIDE_W-1:0];
  end

  // accumulate digits, wrap at coordinate width
  always_comb begin
    row_ext   = (COORD_BITS+SIDE_CFG_W)'(row_r) * (COORD_BITS+SIDE_CFG_W)'(s)
                + (COORD_BITS+SIDE_CFG_W)'(q_dig);
    col_ext   = (COORD_BITS+SIDE_CFG_W)'(col_r) * (COORD_BITS+SIDE_CFG_W)'(s)
                + (COORD_BITS+SIDE_CFG_W)'(r_dig);
    row_new   = row_ext[COORD_BITS-1:0];
    col_new   = col_ext[COORD_BITS-1:0];
    level_new = level_r + LEVEL_W'(1);
    lv        = (levels_r == '0) ? LEVEL_W'(1) : levels_r;
  end

  // status
  always_comb begin
    stat.skip       = done_r || (placed_r >= edge_target_r);
    stat.last_level = (level_new >= lv);
    stat.clr_last   = &clr_addr_r;
  end

  // bitmap check and placed count
  always_comb begin
    is_new     = !rd_q[edge_col_r];
    wr_row     = rd_q;
    wr_row[edge_col_r] = 1'b1;
    placed_nxt = placed_r;
    if (is_new && (placed_r != {COUNT_W{1'b1}})) placed_nxt = placed_r + COUNT_W'(1);
    done_nxt   = (placed_nxt >= edge_target_r);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r        <= SIDE_CFG_W'(2);
      levels_r      <= LEVEL_W'(8);
      node_count_r  <= NODE_W'(256);
      edge_target_r <= '0;
      for (int i = 0; i < SLOTS; i++) thr_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIDE:       side_r        <= cfg_wdata[SIDE_CFG_W-1:0];
        REG_LEVELS:     levels_r      <= cfg_wdata[LEVEL_W-1:0];
        REG_NODE_COUNT: node_count_r  <= cfg_wdata[NODE_W-1:0];
        REG_EDGE_TGT:   edge_target_r <= cfg_wdata[COUNT_W-1:0];
        REG_THR_A:      thr_r[0]      <= cfg_wdata;
        REG_THR_B:      thr_r[1]      <= cfg_wdata;
        REG_THR_C:      thr_r[2]      <= cfg_wdata;
        REG_THR_D:      thr_r[3]      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // run counters and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= '0;
      row_r      <= '0;
      col_r      <= '0;
      placed_r   <= '0;
      done_r     <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.restart) begin
        level_r    <= '0;
        row_r      <= '0;
        col_r      <= '0;
        placed_r   <= '0;
        done_r     <= 1'b0;
        clr_addr_r <= '0;
      end else if (cmd.step) begin
        if (stat.last_level) begin
          level_r <= '0;
          row_r   <= '0;
          col_r   <= '0;
        end else begin
          level_r <= level_new;
          row_r   <= row_new;
          col_r   <= col_new;
        end
      end
      if (cmd.ignore) done_r <= 1'b1;
      if (cmd.check) begin
        placed_r <= placed_nxt;
        done_r   <= done_nxt;
      end
      if (cmd.clr_row) clr_addr_r <= clr_addr_r + COORD_BITS'(1);
    end
  end

  // finished edge coordinates
  always_ff @(posedge clk) begin
    if (cmd.step && stat.last_level) begin
      edge_row_r <= row_new;
      edge_col_r <= col_new;
    end
  end

  // bitmap memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_row) begin
      bitmap_mem[clr_addr_r] <= '0;
    end else if (cmd.check) begin
      bitmap_mem[edge_row_r] <= wr_row;
    end
    if (cmd.step && stat.last_level) begin
      rd_q <= bitmap_mem[row_new];
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.check;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      out_row_r    <= OUT_COORD_W'(edge_row_r);
      out_col_r    <= OUT_COORD_W'(edge_col_r);
      out_new_r    <= is_new;
      out_inside_r <= (NODE_W'(edge_row_r) < node_count_r) &&
                      (NODE_W'(edge_col_r) < node_count_r);
      out_fin_r    <= done_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_row   = out_row_r;
  assign out_edge_col   = out_col_r;
  assign out_new_edge   = out_new_r;
  assign out_inside_res = out_inside_r;
  assign out_finished   = out_fin_r;

endmodule

// ===== hw/rtl/stochastic_kronecker_edge_sampler_top.sv =====
// A draw that does not complete an edge is taken and busy stays low.
// A draw that completes an edge keeps busy high for one cycle (bitmap row read,
// then read-modify-write); out_valid is registered from the check state entered after accept.
// Reset and every restart request run a bitmap clearing pass over all 256 rows, one
// row per cycle, with busy high; configuration writes are taken throughout.
// Results are shown for one cycle only; the receiver cannot stall.
`timescale 1ns / 1ps
`include "stochastic_kronecker_edge_sampler_top_defines.svh"
// ----------------------------------------------------------------------------
// Stochastic Kronecker edge sampler
// Samples graph edges digit by digit and tracks placed edges in a bitmap
// ----------------------------------------------------------------------------
module stochastic_kronecker_edge_sampler_top
  import ske_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_cmd,
  input  logic [DRAW_W-1:0]      in_draw,
  output logic                   out_valid,
  output logic [OUT_COORD_W-1:0] out_edge_row,
  output logic [OUT_COORD_W-1:0] out_edge_col,
  output logic                   out_new_edge,
  output logic                   out_inside_res,
  output logic                   out_finished
);

  ske_cmd_t  ctl_cmd;
  ske_stat_t dp_stat;

  // sequencer
  ske_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_cmd(in_cmd),
    .stat  (dp_stat),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  // registers, compare and bitmap
  ske_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_draw       (in_draw),
    .cmd           (ctl_cmd),
    .stat          (dp_stat),
    .out_valid     (out_valid),
    .out_edge_row  (out_edge_row),
    .out_edge_col  (out_edge_col),
    .out_new_edge  (out_new_edge),
    .out_inside_res(out_inside_res),
    .out_finished  (out_finished)
  );

  // checks
  `SKE_ASSERT_NXT(a_check_gives_result, clk, rst_n, ctl_cmd.check, out_valid)
  `SKE_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `SKE_ASSERT_IMP(a_result_when_idle, clk, rst_n, out_valid, !busy)
  `SKE_ASSERT_NXT(a_restart_clears, clk, rst_n, start && !busy && in_cmd, busy)

endmodule

// ===== tb/stochastic_kronecker_edge_sampler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kronecker edge sampler testbench
// Feeds draw and restart requests with random gaps, predicts every finished
// edge, its bitmap flag, range flag and done flag, and compares each strobed
// result in order against the prediction
// ----------------------------------------------------------------------------
module stochastic_kronecker_edge_sampler_top_tb;
  import ske_pkg::*;

  localparam int unsigned ITEM_GOAL    = 1650;
  localparam int unsigned PHASE_CAP    = 200;
  localparam int unsigned DRAIN_LIMIT  = 50000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;

  typedef enum int unsigned {GAP_NONE, GAP_RANDOM, GAP_SPARSE} gap_mode_e;
  typedef enum int unsigned {THR_SPREAD, THR_RANDOM, THR_ZERO, THR_ONES} thr_style_e;

  // one request as queued for the driver
  typedef struct {
    logic              cmd;
    logic [DRAW_W-1:0] draw;
    int unsigned       gap;
  } draw_req_t;

  // one sampled edge as reported
  typedef struct packed {
    logic [OUT_COORD_W-1:0] row;
    logic [OUT_COORD_W-1:0] col;
    logic                   fresh;
    logic                   in_range;
    logic                   finished;
  } edge_rec_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   in_cmd = CMD_DRAW;
  logic [DRAW_W-1:0]      in_draw = '0;
  logic                   out_valid;
  logic [OUT_COORD_W-1:0] out_edge_row;
  logic [OUT_COORD_W-1:0] out_edge_col;
  logic                   out_new_edge;
  logic                   out_inside_res;
  logic                   out_finished;

  stochastic_kronecker_edge_sampler_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_draw       (in_draw),
    .out_valid     (out_valid),
    .out_edge_row  (out_edge_row),
    .out_edge_col  (out_edge_col),
    .out_new_edge  (out_new_edge),
    .out_inside_res(out_inside_res),
    .out_finished  (out_finished)
  );

  always #10 clk = ~clk;

  // stimulus side
  draw_req_t             pending_reqs[$];
  gap_mode_e             gap_mode = GAP_NONE;
  logic [CFG_DATA_W-1:0] prog_thr [SLOTS];
  int unsigned           idle_left = 0;
  logic                  req_taken = 1'b0;

  // predictor copy of the registers
  logic [SIDE_CFG_W-1:0] cfg_side;
  logic [LEVEL_W-1:0]    cfg_levels;
  logic [NODE_W-1:0]     cfg_nodes;
  logic [COUNT_W-1:0]    cfg_target;
  logic [CFG_DATA_W-1:0] cfg_thr [SLOTS];

  // predictor copy of the walk and the placed-edge bitmap
  bit                    placed_map [int unsigned];
  logic [LEVEL_W-1:0]    depth_cnt;
  logic [COORD_BITS-1:0] row_acc;
  logic [COORD_BITS-1:0] col_acc;
  logic [COUNT_W-1:0]    placed_cnt;
  logic                  target_met;

  edge_rec_t             expected_edges[$];
  int unsigned           live_draws = 0;
  int unsigned           mismatches = 0;

  function automatic void clear_walk();
    placed_map.delete();
    depth_cnt  = '0;
    row_acc    = '0;
    col_acc    = '0;
    placed_cnt = '0;
    target_met = 1'b0;
  endfunction

  // one request through the sampler; returns 1 when an edge result follows
  function automatic bit sample_digit(input logic cmd, input logic [DRAW_W-1:0] draw,
                                      output edge_rec_t rec);
    int unsigned s;
    int unsigned cells;
    int unsigned hit;
    int unsigned lv;
    int unsigned key;
    logic [PROB_BITS-1:0] val;
    rec = '0;
    val = draw[PROB_BITS-1:0];
    live_draws++;
    if (cmd == CMD_RESTART) begin
      clear_walk();
      return 1'b0;
    end
    if (target_met || placed_cnt >= cfg_target) begin
      target_met = 1'b1;
      return 1'b0;
    end
    s = (cfg_side < 2) ? 2 : ((cfg_side > MAX_SIDE) ? MAX_SIDE : cfg_side);
    cells = s * s;
    // first cell at or above the draw; the last cell always matches
    hit = cells - 1;
    for (int k = int'(cells) - 2; k >= 0; k--) begin
      if (val <= cfg_thr[k / 4][(k % 4) * 16 +: PROB_BITS])
        hit = k;
    end
    row_acc   = row_acc * s + hit / s;
    col_acc   = col_acc * s + hit % s;
    depth_cnt = depth_cnt + 1'b1;
    lv = (cfg_levels == 0) ? 1 : cfg_levels;
    if (depth_cnt < lv)
      return 1'b0;
    rec.row   = row_acc;
    rec.col   = col_acc;
    depth_cnt = '0;
    row_acc   = '0;
    col_acc   = '0;
    // bitmap check and set
    key = {rec.row, rec.col};
    rec.fresh = !placed_map.exists(key);
    if (rec.fresh) begin
      placed_map[key] = 1'b1;
      if (placed_cnt != '1)
        placed_cnt++;
    end
    if (placed_cnt >= cfg_target)
      target_met = 1'b1;
    rec.in_range = (rec.row < cfg_nodes) && (rec.col < cfg_nodes);
    rec.finished = target_met;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // result check, register tracking and prediction of accepted requests
  always @(posedge clk) begin
    edge_rec_t got;
    edge_rec_t want;
    edge_rec_t pred;
    if (!rst_n) begin
      req_taken  = 1'b0;
      cfg_side   = 3'd2;
      cfg_levels = 4'd8;
      cfg_nodes  = 9'd256;
      cfg_target = '0;
      foreach (cfg_thr[i]) cfg_thr[i] = '0;
      clear_walk();
      expected_edges.delete();
    end else begin
      if (out_valid) begin
        got.row      = out_edge_row;
        got.col      = out_edge_col;
        got.fresh    = out_new_edge;
        got.in_range = out_inside_res;
        got.finished = out_finished;
        if (expected_edges.size() == 0) begin
          $error("edge (%0d,%0d) reported with none pending", got.row, got.col);
          mismatches++;
        end else begin
          want = expected_edges.pop_front();
          check_field("edge_row", want.row, got.row);
          check_field("edge_col", want.col, got.col);
          check_field("new_edge", want.fresh, got.fresh);
          check_field("inside_res", want.in_range, got.in_range);
          check_field("finished", want.finished, got.finished);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIDE:       cfg_side   = cfg_wdata[SIDE_CFG_W-1:0];
          REG_LEVELS:     cfg_levels = cfg_wdata[LEVEL_W-1:0];
          REG_NODE_COUNT: cfg_nodes  = cfg_wdata[NODE_W-1:0];
          REG_EDGE_TGT:   cfg_target = cfg_wdata[COUNT_W-1:0];
          REG_THR_A:      cfg_thr[0] = cfg_wdata;
          REG_THR_B:      cfg_thr[1] = cfg_wdata;
          REG_THR_C:      cfg_thr[2] = cfg_wdata;
          REG_THR_D:      cfg_thr[3] = cfg_wdata;
          default: ;
        endcase
      end
      req_taken = start && !busy;
      if (req_taken && sample_digit(in_cmd, in_draw, pred))
        expected_edges.push_back(pred);
    end
  end

  // request driver: holds start until taken, then idles for the drawn gap
  always @(negedge clk) begin
    draw_req_t req;
    logic drive;
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      drive = start && !req_taken;
      if (!drive) begin
        if (idle_left != 0) begin
          idle_left--;
        end else if (pending_reqs.size() != 0) begin
          req = pending_reqs.pop_front();
          in_cmd  <= req.cmd;
          in_draw <= req.draw;
          idle_left = req.gap;
          drive = 1'b1;
        end
      end
      start <= drive;
    end
  end

  task automatic push_req(input logic cmd, input logic [DRAW_W-1:0] draw);
    draw_req_t r;
    r.cmd  = cmd;
    r.draw = draw;
    case (gap_mode)
      GAP_NONE:   r.gap = 0;
      GAP_RANDOM: r.gap = $urandom_range(0, 8);
      default:    r.gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0;
    endcase
    pending_reqs.push_back(r);
  endtask

  // draw biased toward the extremes and onto the cell thresholds
  function automatic logic [DRAW_W-1:0] pick_draw(input int unsigned cells);
    int unsigned r;
    int unsigned k;
    logic [DRAW_W-1:0] t;
    r = $urandom_range(0, 15);
    k = $urandom_range(0, cells - 1);
    t = prog_thr[k / 4][(k % 4) * 16 +: 16];
    if (r == 0)
      return '0;
    if (r == 1)
      return '1;
    if (r < 4)
      return t + DRAW_W'(r - 2);
    return DRAW_W'($urandom);
  endfunction

  function automatic void make_thresholds(input thr_style_e style, input int unsigned cells);
    logic [15:0] v;
    for (int k = 0; k < MAX_CELLS; k++) begin
      case (style)
        THR_SPREAD: begin
          // rising cumulative values, jitter below half the spacing
          if (k < int'(cells) - 1)
            v = 16'((k + 1) * 65536 / cells - 1 - $urandom_range(0, 32768 / cells));
          else
            v = 16'($urandom);
        end
        THR_RANDOM: v = 16'($urandom);
        THR_ZERO:   v = '0;
        default:    v = '1;
      endcase
      prog_thr[k / 4][(k % 4) * 16 +: 16] = v;
    end
  endfunction

  // write every register, thresholds from prog_thr
  task automatic write_regs(input logic [SIDE_CFG_W-1:0] side, input logic [LEVEL_W-1:0] lv,
                            input logic [NODE_W-1:0] nodes, input logic [COUNT_W-1:0] tgt);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_SIDE]       = CFG_DATA_W'(side);
    vals[REG_LEVELS]     = CFG_DATA_W'(lv);
    vals[REG_NODE_COUNT] = CFG_DATA_W'(nodes);
    vals[REG_EDGE_TGT]   = CFG_DATA_W'(tgt);
    vals[REG_THR_A]      = prog_thr[0];
    vals[REG_THR_B]      = prog_thr[1];
    vals[REG_THR_C]      = prog_thr[2];
    vals[REG_THR_D]      = prog_thr[3];
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every request is taken, every edge reported and the block idle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while ((pending_reqs.size() != 0 || start || busy || expected_edges.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int unsigned side;
    int unsigned s_eff;
    int unsigned lv;
    int unsigned lv_eff;
    int unsigned lvl_cap;
    int unsigned nodes;
    int unsigned tgt;
    int unsigned span;
    int unsigned reach;
    int unsigned n;
    int unsigned sent;
    int unsigned edges;
    int unsigned r;
    int unsigned phase;
    int unsigned cut;
    foreach (prog_thr[i]) prog_thr[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero draw, top draw, draw exactly on a threshold, target reached
    gap_mode = GAP_NONE;
    prog_thr[0] = {16'hFFFF, 16'hBFFF, 16'h7FFF, 16'h0000};
    write_regs(3'd2, 4'd1, 9'd1, 17'd3);
    push_req(CMD_DRAW, 16'h0000);
    push_req(CMD_DRAW, 16'hFFFF);
    push_req(CMD_DRAW, 16'h7FFF);
    push_req(CMD_DRAW, 16'h8000);
    push_req(CMD_RESTART, 16'hFFFF);
    push_req(CMD_DRAW, 16'h0000);
    push_req(CMD_DRAW, 16'h0000);
    drain();

    // directed: side above range, levels zero, unreachable target
    gap_mode = GAP_RANDOM;
    make_thresholds(THR_SPREAD, MAX_CELLS);
    write_regs(3'd7, 4'd0, 9'd256, 17'h1FFFF);
    push_req(CMD_DRAW, 16'h0000);
    push_req(CMD_DRAW, 16'hFFFF);
    push_req(CMD_DRAW, 16'h8000);
    drain();

    // directed: coordinates wrap past 256 nodes
    write_regs(3'd4, 4'd5, 9'd200, 17'd65536);
    push_req(CMD_RESTART, 16'h0000);
    repeat (5) push_req(CMD_DRAW, 16'hFFFF);
    repeat (5) push_req(CMD_DRAW, 16'h0000);
    drain();

    // directed: side below range, node count zero, finish on the first edge
    write_regs(3'd1, 4'd2, 9'd0, 17'd1);
    push_req(CMD_RESTART, 16'h5A5A);
    push_req(CMD_DRAW, 16'hFFFF);
    push_req(CMD_DRAW, 16'hFFFF);
    push_req(CMD_DRAW, 16'h0000);
    drain();

    // random phases
    phase = 0;
    while (live_draws < ITEM_GOAL && phase < PHASE_CAP) begin
      phase++;
      r = $urandom_range(0, 2);
      gap_mode = (r == 0) ? GAP_NONE : ((r == 1) ? GAP_RANDOM : GAP_SPARSE);

      side  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(2, MAX_SIDE);
      s_eff = (side < 2) ? 2 : ((side > MAX_SIDE) ? MAX_SIDE : side);
      lvl_cap = (s_eff == 2) ? 8 : ((s_eff == 3) ? 5 : 4);
      lv = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, lvl_cap);
      lv_eff = (lv == 0) ? 1 : lv;
      span = 1;
      for (int i = 0; i < int'(lv_eff) && span < 256; i++) span = span * s_eff;
      reach = (span >= 256) ? 65536 : span * span;

      r = $urandom_range(0, 7);
      if (r == 0)
        nodes = $urandom_range(0, 511);
      else if (r == 1)
        nodes = 1;
      else if (r == 2)
        nodes = 256;
      else
        nodes = $urandom_range(1, 256);

      r = $urandom_range(0, 11);
      if (r == 0)
        tgt = 0;
      else if (r < 4)
        tgt = $urandom_range(1, 12);
      else if (r < 7)
        tgt = $urandom_range(1, reach);
      else if (r < 9)
        tgt = reach + 1;
      else
        tgt = ($urandom_range(0, 1) == 0) ? 65536 : 17'h1FFFF;

      r = $urandom_range(0, 99);
      if (r < 60)
        make_thresholds(THR_SPREAD, s_eff * s_eff);
      else if (r < 85)
        make_thresholds(THR_RANDOM, s_eff * s_eff);
      else if (r < 93)
        make_thresholds(THR_ZERO, s_eff * s_eff);
      else
        make_thresholds(THR_ONES, s_eff * s_eff);
      write_regs(SIDE_CFG_W'(side), LEVEL_W'(lv), NODE_W'(nodes), COUNT_W'(tgt));

      n = $urandom_range(40, 150);
      if ($urandom_range(0, 9) < 7)
        push_req(CMD_RESTART, DRAW_W'($urandom));
      sent  = 0;
      edges = 0;
      while (sent < n) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // whole edge, one draw per level
          for (int i = 0; i < int'(lv_eff); i++) push_req(CMD_DRAW, pick_draw(s_eff * s_eff));
          sent += lv_eff;
          edges++;
        end else if (r < 90) begin
          // stray draw, shifts the level alignment
          push_req(CMD_DRAW, pick_draw(s_eff * s_eff));
          sent++;
        end else if (r < 98) begin
          // broken edge, cut short and sometimes abandoned by a restart
          cut = $urandom_range(1, lv_eff);
          for (int i = 0; i < int'(cut); i++) push_req(CMD_DRAW, pick_draw(s_eff * s_eff));
          sent += cut;
          if (r >= 96) begin
            push_req(CMD_RESTART, DRAW_W'($urandom));
            sent++;
          end
        end else begin
          push_req(CMD_RESTART, DRAW_W'($urandom));
          sent++;
        end
        // small targets finish early; start over so draws keep counting
        if (tgt <= 12 && edges > tgt + 2) begin
          push_req(CMD_RESTART, DRAW_W'($urandom));
          edges = 0;
        end
      end
      drain();
    end

    drain();
    if (expected_edges.size() != 0) begin
      $error("%0d edges never reported", expected_edges.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
